@@ hdl/ffra_pkg.sv @@
package ffra_pkg;

  localparam int GRID_W = 64;
  localparam int GRID_H = 64;
  localparam int COL_W = $clog2(GRID_W);
  localparam int ROW_W = $clog2(GRID_H);
  localparam int SIZE_W = 7;
  localparam int STEP_W = $clog2(SIZE_W);
  localparam int TAG_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 1'd1;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] rect_width;
    logic [SIZE_W-1:0] rect_height;
    logic [TAG_W-1:0]  request_tag;
  } req_t;

  typedef struct packed {
    logic             placed;
    logic [COL_W-1:0] pos_x;
    logic [ROW_W-1:0] pos_y;
    logic [TAG_W-1:0] result_tag;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_RUN,
    ST_PICK,
    ST_MARK,
    ST_MLAST,
    ST_DONE
  } state_t;

endpackage

@@ hdl/ffra_if.sv @@
interface ffra_req_if;
  logic           valid;
  logic           ready;
  ffra_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ffra_rsp_if;
  logic           valid;
  logic           ready;
  ffra_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/ffra_ram.sv @@
module ffra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/first_fit_rect_allocator_top.sv @@
// First-fit rectangle allocator over a 64 x 64 occupancy bitmap.
// in_req carries place (mode 0) and clear (mode 1) transactions; out_rsp
// returns one result per transaction, in order, with the tag echoed.
// cfg_we/cfg_idx/cfg_data write atlas_width (index 0) and atlas_height
// (index 1), saturated to 64; every write frees the whole grid.
// Clear and zero-sized requests go from acceptance straight to the done state.
// A place request reads the grid rows of each candidate top row, one row
// per cycle from the single-read-port row memory, then resolves the
// leftmost fitting column with a 7-step run search, over up to (ah - h + 1)
// candidate top rows; it then marks the rows by read-modify-write and
// posts the result.
// One transaction is in flight at a time; in_req.ready is high while idle.
// A finished result sits in the output register while the next
// transaction is accepted; while the receiver stalls, a second result
// holds inside the block until the output register frees.
// Synchronous reset sets both atlas sizes to 64 and frees every cell at
// once through per-row valid flags; a clear request frees every cell the same way.
module first_fit_rect_allocator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  ffra_req_if.sink                         in_req,
  ffra_rsp_if.source                       out_rsp,
  input  logic                             cfg_we,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ffra_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ffra_pkg::*;

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic [GRID_H-1:0] valid_r, valid_nxt;
  logic [SIZE_W-1:0] w_r, w_nxt;
  logic [SIZE_W-1:0] h_r, h_nxt;
  logic [ROW_W-1:0]  y_r, y_nxt;
  logic [SIZE_W-1:0] rcnt_r, rcnt_nxt;
  logic [GRID_W-1:0] busy_r, busy_nxt;
  logic [GRID_W-1:0] acc_r, acc_nxt;
  logic [GRID_W-1:0] pv_r, pv_nxt;
  logic [SIZE_W-1:0] cur_r, cur_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [COL_W-1:0]  x_r, x_nxt;
  logic [GRID_W-1:0] mask_r, mask_nxt;
  logic              rd_q_r, rd_q_nxt;
  logic              rvld_r, rvld_nxt;
  logic [ROW_W-1:0]  rd_addr_q_r, rd_addr_q_nxt;
  rsp_t              res_r, res_nxt;
  rsp_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_fire;
  logic              rd_en;
  logic [ROW_W-1:0]  rd_addr;
  logic [GRID_W-1:0] ram_rdata;
  logic [GRID_W-1:0] row_data;
  logic [GRID_W-1:0] col_mask;
  logic [COL_W-1:0]  first_col;
  logic              ram_we;
  logic [SIZE_W-1:0] step_amt;
  logic [SIZE_W-1:0] cfg_sat;
  logic [SIZE_W:0]   next_bottom;

  assign in_fire = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.payload = out_r;

  assign rd_en = (state_r == ST_READ) || (state_r == ST_MARK);
  assign rd_addr = y_r + rcnt_r[ROW_W-1:0];
  assign row_data = rvld_r ? ram_rdata : '0;
  assign ram_we = rd_q_r && ((state_r == ST_MARK) || (state_r == ST_MLAST));
  assign step_amt = SIZE_W'(1) << step_r;
  assign cfg_sat = (cfg_data > SIZE_W'(GRID_W)) ? SIZE_W'(GRID_W) : cfg_data;
  assign next_bottom = (SIZE_W+1)'(y_r) + (SIZE_W+1)'(1) + (SIZE_W+1)'(h_r);

  always_comb begin
    for (int i = 0; i < GRID_W; i++) begin
      col_mask[i] = (SIZE_W'(i) < width_r);
    end
  end

  always_comb begin
    first_col = '0;
    for (int i = GRID_W - 1; i >= 0; i--) begin
      if (acc_r[i]) begin
        first_col = COL_W'(i);
      end
    end
  end

  ffra_ram #(
    .WIDTH (GRID_W),
    .DEPTH (GRID_H)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr_q_r),
    .wdata (row_data | mask_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= SIZE_W'(GRID_W);
      height_r    <= SIZE_W'(GRID_H);
      valid_r     <= '0;
      rd_q_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      valid_r     <= valid_nxt;
      rd_q_r      <= rd_q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    y_r         <= y_nxt;
    rcnt_r      <= rcnt_nxt;
    busy_r      <= busy_nxt;
    acc_r       <= acc_nxt;
    pv_r        <= pv_nxt;
    cur_r       <= cur_nxt;
    step_r      <= step_nxt;
    x_r         <= x_nxt;
    mask_r      <= mask_nxt;
    rvld_r      <= rvld_nxt;
    rd_addr_q_r <= rd_addr_q_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    valid_nxt     = valid_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    y_nxt         = y_r;
    rcnt_nxt      = rcnt_r;
    busy_nxt      = busy_r;
    acc_nxt       = acc_r;
    pv_nxt        = pv_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    x_nxt         = x_r;
    mask_nxt      = mask_r;
    rd_q_nxt      = rd_en;
    rvld_nxt      = valid_r[rd_addr];
    rd_addr_q_nxt = rd_addr;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (ram_we) begin
      valid_nxt[rd_addr_q_r] = 1'b1;
    end

    if (cfg_we) begin
      case (cfg_idx)
        CFG_ATLAS_WIDTH: begin
          width_nxt = cfg_sat;
          valid_nxt = '0;
        end
        CFG_ATLAS_HEIGHT: begin
          height_nxt = cfg_sat;
          valid_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          w_nxt = in_req.payload.rect_width;
          h_nxt = in_req.payload.rect_height;
          res_nxt.placed = 1'b0;
          res_nxt.pos_x = '0;
          res_nxt.pos_y = '0;
          res_nxt.result_tag = in_req.payload.request_tag;
          y_nxt = '0;
          rcnt_nxt = '0;
          busy_nxt = '0;
          if (in_req.payload.mode == MODE_CLEAR) begin
            valid_nxt = '0;
            res_nxt.placed = 1'b1;
            state_nxt = ST_DONE;
          end else if ((in_req.payload.rect_width == '0) ||
                       (in_req.payload.rect_height == '0)) begin
            res_nxt.placed = (width_r != '0) && (height_r != '0) &&
                             (in_req.payload.rect_width <= width_r) &&
                             (in_req.payload.rect_height <= height_r);
            state_nxt = ST_DONE;
          end else if (in_req.payload.rect_height > height_r) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (rd_q_r) begin
          busy_nxt = busy_r | row_data;
        end
        if (rcnt_r == h_r - SIZE_W'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          rcnt_nxt = rcnt_r + SIZE_W'(1);
        end
      end
      ST_DRAIN: begin
        pv_nxt = ~(busy_r | row_data) & col_mask;
        acc_nxt = '1;
        cur_nxt = '0;
        step_nxt = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (w_r[step_r]) begin
          acc_nxt = acc_r & (pv_r >> cur_r);
          cur_nxt = cur_r + step_amt;
        end
        pv_nxt = pv_r & (pv_r >> step_amt);
        if (step_r == STEP_W'(SIZE_W - 1)) begin
          state_nxt = ST_PICK;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_PICK: begin
        rcnt_nxt = '0;
        busy_nxt = '0;
        if (acc_r != '0) begin
          x_nxt = first_col;
          mask_nxt = ({GRID_W{1'b1}} >> (SIZE_W'(GRID_W) - w_r)) << first_col;
          state_nxt = ST_MARK;
        end else if (next_bottom <= (SIZE_W+1)'(height_r)) begin
          y_nxt = y_r + ROW_W'(1);
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MARK: begin
        if (rcnt_r == h_r - SIZE_W'(1)) begin
          state_nxt = ST_MLAST;
        end else begin
          rcnt_nxt = rcnt_r + SIZE_W'(1);
        end
      end
      ST_MLAST: begin
        res_nxt.placed = 1'b1;
        res_nxt.pos_x = x_r;
        res_nxt.pos_y = y_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_mark_in_atlas: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MLAST) |->
      ((SIZE_W+1)'(x_r) + (SIZE_W+1)'(w_r) <= (SIZE_W+1)'(width_r)))
    else $error("placed rectangle crosses the atlas edge");

  a_clear_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_req.payload.mode == MODE_CLEAR)) |=> (valid_r == '0))
    else $error("clear transaction left occupied rows");

  a_rmw_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && rd_en) |-> (rd_addr_q_r != rd_addr))
    else $error("row write and read collide");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result posted outside the done state");
`endif

endmodule

@@ test/first_fit_rect_allocator_top_tb.sv @@
`timescale 1ns / 100ps

module first_fit_rect_allocator_top_tb;
  import ffra_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int LONG_HOLD = 400;

  class atlas_scoreboard;
    logic [GRID_W-1:0] occupancy [GRID_H];
    int unsigned atlas_w;
    int unsigned atlas_h;
    rsp_t expected_spots [$];
    int mismatches;

    function new();
      free_grid();
      atlas_w = GRID_W;
      atlas_h = GRID_H;
      mismatches = 0;
    endfunction

    function void free_grid();
      foreach (occupancy[i]) occupancy[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int unsigned size;
      size = (data > GRID_W) ? GRID_W : 32'(data);
      if (idx == CFG_ATLAS_WIDTH) begin
        atlas_w = size;
      end else begin
        atlas_h = size;
      end
      free_grid();
    endfunction

    function rsp_t first_fit(req_t rq);
      rsp_t res;
      int unsigned w;
      int unsigned h;
      logic [GRID_W:0] ones;
      logic [GRID_W-1:0] span;
      bit clash;
      res = '0;
      res.result_tag = rq.request_tag;
      w = 32'(rq.rect_width);
      h = 32'(rq.rect_height);
      if (w > atlas_w || h > atlas_h) return res;
      ones = ((GRID_W+1)'(1) << w) - 1'b1;
      for (int y = 0; y < atlas_h && y + h <= atlas_h; y++) begin
        for (int x = 0; x < atlas_w && x + w <= atlas_w; x++) begin
          span = ones[GRID_W-1:0] << x;
          clash = 1'b0;
          for (int r = 0; r < h; r++) begin
            if ((occupancy[y+r] & span) != '0) clash = 1'b1;
          end
          if (!clash) begin
            for (int r = 0; r < h; r++) occupancy[y+r] |= span;
            res.placed = 1'b1;
            res.pos_x = COL_W'(x);
            res.pos_y = ROW_W'(y);
            return res;
          end
        end
      end
      return res;
    endfunction

    function void note_request(req_t rq);
      rsp_t res;
      if (rq.mode == MODE_CLEAR) begin
        free_grid();
        res = '0;
        res.placed = 1'b1;
        res.result_tag = rq.request_tag;
      end else begin
        res = first_fit(rq);
      end
      expected_spots.push_back(res);
    endfunction

    function int outstanding();
      return expected_spots.size();
    endfunction

    task report_mismatch(string field, logic [7:0] got, logic [7:0] want);
      mismatches++;
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (expected_spots.size() == 0) begin
        report_mismatch("unrequested result tag", got.result_tag, 8'd0);
        return;
      end
      want = expected_spots.pop_front();
      if (got.placed !== want.placed)
        report_mismatch("placed", 8'(got.placed), 8'(want.placed));
      if (got.pos_x !== want.pos_x)
        report_mismatch("pos_x", 8'(got.pos_x), 8'(want.pos_x));
      if (got.pos_y !== want.pos_y)
        report_mismatch("pos_y", 8'(got.pos_y), 8'(want.pos_y));
      if (got.result_tag !== want.result_tag)
        report_mismatch("result_tag", got.result_tag, want.result_tag);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ffra_req_if req_ch ();
  ffra_rsp_if rsp_ch ();

  atlas_scoreboard sb;
  bit calm;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int cycle_count = 0;

  first_fit_rect_allocator_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_rsp  (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each transaction, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) sb.check_result(rsp_ch.payload);
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 17);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic req_t make_req(logic mode, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                                    logic [TAG_W-1:0] tag);
    req_t rq;
    rq.mode = mode;
    rq.rect_width = w;
    rq.rect_height = h;
    rq.request_tag = tag;
    return rq;
  endfunction

  function automatic req_t random_req();
    int unsigned reach_w;
    int unsigned reach_h;
    int unsigned pick;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    reach_w = sb.atlas_w / 2 + 2;
    reach_h = sb.atlas_h / 2 + 2;
    pick = $urandom_range(0, 15);
    if (pick == 1) begin
      w = SIZE_W'($urandom_range(0, 127));
      h = SIZE_W'($urandom_range(0, 127));
    end else if (pick == 2) begin
      w = $urandom_range(0, 1) ? '0 : SIZE_W'($urandom_range(0, reach_w));
      h = (w != '0) ? '0 : SIZE_W'($urandom_range(0, reach_h));
    end else begin
      w = SIZE_W'($urandom_range(1, reach_w));
      h = SIZE_W'($urandom_range(1, reach_h));
    end
    return make_req((pick == 0) ? MODE_CLEAR : MODE_PLACE, w, h, TAG_W'($urandom_range(0, 255)));
  endfunction

  task send_req(req_t rq);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= rq;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(rq);
  endtask

  task pause_until_drained();
    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    pause_until_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task run_phase(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h, int count);
    cfg_write(CFG_ATLAS_WIDTH, w);
    cfg_write(CFG_ATLAS_HEIGHT, h);
    repeat (count) send_req(random_req());
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size 64 x 64: full grid, zero sizes, oversized shapes, far corners
    send_req(make_req(MODE_PLACE, 7'd0, 7'd0, 8'h00));
    send_req(make_req(MODE_PLACE, 7'd64, 7'd64, 8'hff));
    send_req(make_req(MODE_PLACE, 7'd1, 7'd1, 8'h01));
    send_req(make_req(MODE_PLACE, 7'd0, 7'd0, 8'h02));
    send_req(make_req(MODE_CLEAR, 7'd0, 7'd0, 8'h03));
    send_req(make_req(MODE_PLACE, 7'd65, 7'd1, 8'h04));
    send_req(make_req(MODE_PLACE, 7'd1, 7'd65, 8'h05));
    send_req(make_req(MODE_PLACE, 7'd127, 7'd127, 8'h80));
    send_req(make_req(MODE_PLACE, 7'd0, 7'd5, 8'h06));
    send_req(make_req(MODE_PLACE, 7'd5, 7'd0, 8'h07));
    send_req(make_req(MODE_PLACE, 7'd63, 7'd1, 8'h08));
    send_req(make_req(MODE_PLACE, 7'd2, 7'd1, 8'h09));
    send_req(make_req(MODE_PLACE, 7'd1, 7'd1, 8'h0a));
    send_req(make_req(MODE_PLACE, 7'd64, 7'd63, 8'h0b));
    send_req(make_req(MODE_PLACE, 7'd62, 7'd63, 8'h0c));
    send_req(make_req(MODE_PLACE, 7'd1, 7'd1, 8'h55));
    send_req(make_req(MODE_CLEAR, 7'd127, 7'd127, 8'haa));

    // zero-wide atlas: nothing fits, not even an empty shape
    cfg_write(CFG_ATLAS_WIDTH, 7'd0);
    send_req(make_req(MODE_PLACE, 7'd0, 7'd0, 8'h10));
    send_req(make_req(MODE_PLACE, 7'd1, 7'd1, 8'h11));

    // oversized width saturates, single row
    cfg_write(CFG_ATLAS_WIDTH, 7'd127);
    cfg_write(CFG_ATLAS_HEIGHT, 7'd1);
    send_req(make_req(MODE_PLACE, 7'd64, 7'd1, 8'h12));
    send_req(make_req(MODE_PLACE, 7'd1, 7'd1, 8'h13));
    send_req(make_req(MODE_PLACE, 7'd64, 7'd2, 8'h14));

    run_phase(7'd8, 7'd6, 12);
    hold_go = 1'b1;
    repeat (14) send_req(random_req());
    run_phase(7'd1, 7'd1, 10);
    run_phase(7'd127, 7'd3, 8);
    pause_until_drained();
    repeat (7) send_req(random_req());
    run_phase(7'd5, 7'd13, 18);
    run_phase(7'd0, 7'd9, 4);
    run_phase(7'd1, 7'd64, 12);
    run_phase(7'd64, 7'd64, 15);
    run_phase(7'd16, 7'd16, 18);
    calm = 1'b1;
    run_phase(7'd10, 7'd10, 20);

    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
